FILE: rtl/srle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srle_pkg;

	localparam int MAX_RUN    = 255;
	localparam int RUN_W      = 8;
	localparam int CH_W       = 8;
	localparam int THR_W      = 10;
	localparam int THR_RESET  = 10;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pixel_t;

	// one request per pixel that closes at least one run
	typedef struct packed {
		logic             brk;
		logic [RUN_W-1:0] brk_len;
		pixel_t           brk_pix;
		logic             row;
		logic [RUN_W-1:0] row_len;
		pixel_t           row_pix;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/srle_front.sv
`timescale 1ns / 1ps
`default_nettype none

module srle_front
	import srle_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [THR_W-1:0]  cfg_wdata,
	input  wire logic              acc,
	input  wire pixel_t            pix,
	input  wire logic              row_end,
	output logic                   push,
	output cmd_t                   cmd
);

	logic [THR_W-1:0] thr_q;
	pixel_t           prev_q;
	logic [RUN_W-1:0] cnt_q;
	logic             open_q;

	logic [THR_W-1:0] diff_sum;
	logic             extend;
	logic [RUN_W-1:0] cnt_next;
	logic             brk;

	assign diff_sum = THR_W'(abs_diff(pix.blue, prev_q.blue))
		+ THR_W'(abs_diff(pix.green, prev_q.green))
		+ THR_W'(abs_diff(pix.red, prev_q.red));

	assign extend = (diff_sum <= thr_q) && (cnt_q < RUN_W'(MAX_RUN));

	always_comb begin
		if (!open_q) begin
			cnt_next = RUN_W'(1);
			brk      = 1'b0;
		end else if (extend) begin
			cnt_next = cnt_q + RUN_W'(1);
			brk      = 1'b0;
		end else begin
			cnt_next = RUN_W'(1);
			brk      = 1'b1;
		end
	end

	always_comb begin
		cmd.brk     = brk;
		cmd.brk_len = cnt_q;
		cmd.brk_pix = prev_q;
		cmd.row     = row_end;
		cmd.row_len = cnt_next;
		cmd.row_pix = pix;
	end

	assign push = acc && (brk || row_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(THR_RESET);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cnt_q  <= '0;
			open_q <= 1'b0;
		end else if (acc) begin
			prev_q <= pix;
			if (row_end) begin
				cnt_q  <= '0;
				open_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_next;
				open_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/srle_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module srle_fifo
	import srle_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  wdata,
	input  wire logic  pop,
	output cmd_t       rdata,
	output q_status_t  status
);

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	assign status.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign rdata        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/srle_back.sv
`timescale 1ns / 1ps
`default_nettype none

module srle_back
	import srle_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic              q_empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [RUN_W-1:0]       run_length,
	output pixel_t                 run_pix,
	output logic                   row_done,
	output logic                   last
);

	logic             valid_q;
	logic [RUN_W-1:0] len_q;
	pixel_t           pix_q;
	logic             done_q;
	logic             last_q;

	// second record of a break-plus-row-end request
	logic             pend_q;
	logic [RUN_W-1:0] pend_len_q;
	pixel_t           pend_pix_q;

	logic load;

	assign load = !valid_q || out_ready;
	assign pop  = load && !pend_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				pend_q  <= cmd.brk && cmd.row;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				len_q  <= pend_len_q;
				pix_q  <= pend_pix_q;
				done_q <= 1'b1;
				last_q <= 1'b1;
			end else if (!q_empty) begin
				if (cmd.brk) begin
					len_q  <= cmd.brk_len;
					pix_q  <= cmd.brk_pix;
					done_q <= 1'b0;
					last_q <= !cmd.row;
				end else begin
					len_q  <= cmd.row_len;
					pix_q  <= cmd.row_pix;
					done_q <= 1'b1;
					last_q <= 1'b1;
				end
				pend_len_q <= cmd.row_len;
				pend_pix_q <= cmd.row_pix;
			end
		end
	end

	assign out_valid  = valid_q;
	assign run_length = len_q;
	assign run_pix    = pix_q;
	assign row_done   = done_q;
	assign last       = last_q;

endmodule

`default_nettype wire

FILE: rtl/similarity_run_length_encoder_core.sv
// Similarity run-length encoder.
// Input channel (in_valid/in_ready): one BGR pixel per request, row_end on the
// last pixel of each row. Output channel (out_valid/out_ready): run records of
// length, the run's last pixel, row_done and last.
// A pixel is taken every clock while the four-entry request queue between the
// classifier and the record emitter has room. The classifier compares each
// pixel with the previous one (summed absolute channel difference against
// the threshold) in the accepting cycle, so there is no gap between
// pixels. A pixel that closes one run produces one record, a run break on a
// row end produces two; the emitter sends one record per clock while
// out_ready is high, so the output port limits a stream of many short runs.
// A record passes from the accepting edge through the request queue and the
// output register before it is valid on the output; the second record of a
// pair is loaded into the output register as the first is taken.
// Stall: when out_ready is low the record holds; the queue fills, then
// in_ready drops until records are taken.
// Reset: threshold back to 10, no run open, queue and output emptied.
// cfg_we writes the threshold at once; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module similarity_run_length_encoder_core
	import srle_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [THR_W-1:0]  cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [CH_W-1:0]   blue,
	input  wire logic [CH_W-1:0]   green,
	input  wire logic [CH_W-1:0]   red,
	input  wire logic              row_end,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [RUN_W-1:0]       run_length,
	output logic [CH_W-1:0]        run_blue,
	output logic [CH_W-1:0]        run_green,
	output logic [CH_W-1:0]        run_red,
	output logic                   row_done,
	output logic                   last
);

	pixel_t    pix;
	pixel_t    run_pix;
	logic      acc;
	logic      push;
	logic      pop;
	cmd_t      cmd_w;
	cmd_t      cmd_r;
	q_status_t q_status;

	assign pix.blue  = blue;
	assign pix.green = green;
	assign pix.red   = red;

	assign in_ready = !q_status.full;
	assign acc      = in_valid && in_ready;

	srle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.pix       (pix),
		.row_end   (row_end),
		.push      (push),
		.cmd       (cmd_w)
	);

	srle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_w),
		.pop    (pop),
		.rdata  (cmd_r),
		.status (q_status)
	);

	srle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_r),
		.q_empty    (q_status.empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.run_length (run_length),
		.run_pix    (run_pix),
		.row_done   (row_done),
		.last       (last)
	);

	assign run_blue  = run_pix.blue;
	assign run_green = run_pix.green;
	assign run_red   = run_pix.red;

endmodule

`default_nettype wire

FILE: rtl/srle_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module srle_checker
	import srle_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [RUN_W-1:0]  run_length,
	input wire logic [CH_W-1:0]   run_blue,
	input wire logic              row_done,
	input wire logic              last
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_length) && $stable(run_blue))
		else $error("stalled record changed");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("zero-length run");

	a_row_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_done |-> last)
		else $error("row close record not marked last");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && row_done)
		else $error("row close record missing after run break");

endmodule

bind similarity_run_length_encoder_core srle_checker u_srle_checker (.*);

`default_nettype wire
